// ===== sv/qth_pkg.sv =====
// ----------------------------------------------------------------------------
// qth_pkg
// Shared widths, fixed-point constants, datapath types and the CORDIC arctan
// table for the quaternion heading pipeline.
// ----------------------------------------------------------------------------
package qth_pkg;

    localparam int QUAT_W           = 16;   // Q2.14 input components
    localparam int HEAD_W           = 17;   // Q4.13 heading
    localparam int REGION_W         = 2;
    localparam int PROD_W           = 2 * QUAT_W;          // exact Q28 products
    localparam int TEST_W           = PROD_W + 1;          // sum of two products
    localparam int VEC_W            = PROD_W + 4;          // CORDIC x/y with gain headroom
    localparam int ANG_W            = 33;                  // Q28 angle, doubled, rounded
    localparam int Q_FRAC           = 14;                  // Q14 -> Q28 alignment
    localparam int HEAD_SHIFT       = 15;                  // Q28 -> Q13
    localparam int ATAN_TABLE_LEN   = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [TEST_W-1:0] TEST_LIMIT_Q28 = TEST_W'(133949292);
    localparam logic signed [VEC_W-1:0]  ONE_Q28        = VEC_W'(268435456);
    localparam logic signed [ANG_W-1:0]  HALF_PI_Q28    = ANG_W'(421657428);
    localparam logic signed [ANG_W-1:0]  ROUND_ADD      = ANG_W'(16384);

    typedef enum logic [REGION_W-1:0] {
        REGION_NORMAL = 2'd0,
        REGION_NORTH  = 2'd1,
        REGION_SOUTH  = 2'd2
    } region_t;

    // one CORDIC vectoring operand set as it travels down the pipeline
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
        region_t                 region;
    } cordic_t;

    // round(atan(2^-i) * 2^28)
    function automatic logic signed [ANG_W-1:0] atan_q28(input int idx);
        logic signed [ANG_W-1:0] val;
        case (idx)
            0:       val = ANG_W'(210828714);
            1:       val = ANG_W'(124459457);
            2:       val = ANG_W'(65760959);
            3:       val = ANG_W'(33381290);
            4:       val = ANG_W'(16755422);
            5:       val = ANG_W'(8385879);
            6:       val = ANG_W'(4193963);
            7:       val = ANG_W'(2097109);
            8:       val = ANG_W'(1048571);
            9:       val = ANG_W'(524287);
            10:      val = ANG_W'(262144);
            11:      val = ANG_W'(131072);
            12:      val = ANG_W'(65536);
            13:      val = ANG_W'(32768);
            14:      val = ANG_W'(16384);
            15:      val = ANG_W'(8192);
            16:      val = ANG_W'(4096);
            17:      val = ANG_W'(2048);
            18:      val = ANG_W'(1024);
            19:      val = ANG_W'(512);
            20:      val = ANG_W'(256);
            21:      val = ANG_W'(128);
            22:      val = ANG_W'(64);
            23:      val = ANG_W'(32);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== sv/quaternion_to_heading.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_heading
// Heading angle (Q4.13 radians) of a Q2.14 orientation quaternion, with a code
// for the branch taken: normal, north or south singularity.
// ----------------------------------------------------------------------------
// The block takes one quaternion per clock while the output is not stalled and
// returns one heading per item in order. Its stages are one for the six 16x16
// products, one for the branch select and quadrant pre-rotation, one per CORDIC
// micro-rotation, and the output register that doubles, negates and rounds the
// angle. Each stage has its own valid bit and ready, so bubbles close up while
// the output is stalled. The singular branches are not wrapped and reach about
// plus or minus two pi.
module quaternion_to_heading
    import qth_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [QUAT_W-1:0] quat_x,
    input  logic signed [QUAT_W-1:0] quat_y,
    input  logic signed [QUAT_W-1:0] quat_z,
    input  logic signed [QUAT_W-1:0] quat_w,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [HEAD_W-1:0] heading,
    output logic [REGION_W-1:0]      region
);

    localparam int NSTEPS = (CORDIC_STEPS < ATAN_TABLE_LEN) ? CORDIC_STEPS : ATAN_TABLE_LEN;

    // product stage
    logic                     s1_valid_reg;
    logic                     s1_ready;
    logic signed [PROD_W-1:0] p_xy_reg;
    logic signed [PROD_W-1:0] p_zw_reg;
    logic signed [PROD_W-1:0] p_yw_reg;
    logic signed [PROD_W-1:0] p_xz_reg;
    logic signed [PROD_W-1:0] p_yy_reg;
    logic signed [PROD_W-1:0] p_zz_reg;
    logic signed [QUAT_W-1:0] qx_reg;
    logic signed [QUAT_W-1:0] qw_reg;

    // select stage
    logic                     s2_valid_reg;
    logic                     s2_ready;
    cordic_t                  s2_data_reg;
    cordic_t                  s2_data_next;
    logic signed [TEST_W-1:0] test;
    logic signed [VEC_W-1:0]  vec_x;
    logic signed [VEC_W-1:0]  vec_y;

    // CORDIC chain
    logic                     st_valid [NSTEPS+1];
    logic                     st_ready [NSTEPS+1];
    cordic_t                  st_data  [NSTEPS+1];

    // output stage
    logic                     out_valid_reg;
    logic                     out_move;
    logic signed [HEAD_W-1:0] heading_reg;
    logic signed [HEAD_W-1:0] heading_next;
    region_t                  region_reg;
    logic signed [ANG_W-1:0]  ang_base;
    logic signed [ANG_W-1:0]  ang;
    logic signed [ANG_W-1:0]  ang_round;
    cordic_t                  fin;

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s2_ready = !s2_valid_reg || st_ready[0];
    assign out_move = !out_valid_reg || out_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            p_xy_reg <= PROD_W'(quat_x) * PROD_W'(quat_y);
            p_zw_reg <= PROD_W'(quat_z) * PROD_W'(quat_w);
            p_yw_reg <= PROD_W'(quat_y) * PROD_W'(quat_w);
            p_xz_reg <= PROD_W'(quat_x) * PROD_W'(quat_z);
            p_yy_reg <= PROD_W'(quat_y) * PROD_W'(quat_y);
            p_zz_reg <= PROD_W'(quat_z) * PROD_W'(quat_z);
            qx_reg   <= quat_x;
            qw_reg   <= quat_w;
        end
    end

    // branch select and quadrant pre-rotation
    always_comb
    begin
        test = TEST_W'(p_xy_reg) + TEST_W'(p_zw_reg);
        s2_data_next = '0;
        if (test > TEST_LIMIT_Q28)
        begin
            s2_data_next.region = REGION_NORTH;
            vec_y = VEC_W'(qx_reg) <<< Q_FRAC;
            vec_x = VEC_W'(qw_reg) <<< Q_FRAC;
        end
        else if (test < -TEST_LIMIT_Q28)
        begin
            s2_data_next.region = REGION_SOUTH;
            vec_y = VEC_W'(qx_reg) <<< Q_FRAC;
            vec_x = VEC_W'(qw_reg) <<< Q_FRAC;
        end
        else
        begin
            s2_data_next.region = REGION_NORMAL;
            vec_y = (VEC_W'(p_yw_reg) - VEC_W'(p_xz_reg)) <<< 1;
            vec_x = ONE_Q28 - (VEC_W'(p_yy_reg) <<< 1) - (VEC_W'(p_zz_reg) <<< 1);
        end
        s2_data_next.zero = (vec_x == '0) && (vec_y == '0);
        if (vec_x[VEC_W-1])
        begin
            if (!vec_y[VEC_W-1])
            begin
                s2_data_next.x = vec_y;
                s2_data_next.y = -vec_x;
                s2_data_next.z = HALF_PI_Q28;
            end
            else
            begin
                s2_data_next.x = -vec_y;
                s2_data_next.y = vec_x;
                s2_data_next.z = -HALF_PI_Q28;
            end
        end
        else
        begin
            s2_data_next.x = vec_x;
            s2_data_next.y = vec_y;
            s2_data_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign st_valid[0] = s2_valid_reg;
    assign st_data[0]  = s2_data_reg;

    for (genvar i = 0; i < NSTEPS; i++)
    begin : g_cordic
        qth_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[i]),
            .in_ready  (st_ready[i]),
            .in_data   (st_data[i]),
            .out_valid (st_valid[i+1]),
            .out_ready (st_ready[i+1]),
            .out_data  (st_data[i+1])
        );
    end

    assign st_ready[NSTEPS] = out_move;
    assign fin              = st_data[NSTEPS];

    // double for the singular branches and negate for the south one, then round to Q13
    always_comb
    begin
        ang_base = fin.zero ? '0 : fin.z;
        case (fin.region)
            REGION_NORTH: ang = ang_base <<< 1;
            REGION_SOUTH: ang = -(ang_base <<< 1);
            default:      ang = ang_base;
        endcase
        ang_round    = (ang + ROUND_ADD) >>> HEAD_SHIFT;
        heading_next = ang_round[HEAD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_move)
        begin
            out_valid_reg <= st_valid[NSTEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_valid[NSTEPS] && out_move)
        begin
            heading_reg <= heading_next;
            region_reg  <= fin.region;
        end
    end

    assign out_valid = out_valid_reg;
    assign heading   = heading_reg;
    assign region    = region_reg;

endmodule

// ===== sv/qth_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// qth_cordic_stage
// One registered CORDIC vectoring micro-rotation with its own valid bit and
// valid/ready handshake, so a stall holds the stage without loss.
// ----------------------------------------------------------------------------
module qth_cordic_stage
    import qth_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  cordic_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output cordic_t out_data
);

    logic                    valid_reg;
    cordic_t                 data_reg;
    cordic_t                 data_next;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        dx        = in_data.y >>> STEP;
        dy        = in_data.x >>> STEP;
        data_next = in_data;
        // drive y toward zero
        if (!in_data.y[VEC_W-1])
        begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + atan_q28(STEP);
        end
        else
        begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - atan_q28(STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== sv/qth_checker.sv =====
// ----------------------------------------------------------------------------
// qth_checker
// Port-level checks for the quaternion heading pipeline, bound to the top.
// ----------------------------------------------------------------------------
module qth_checker
    import qth_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic signed [QUAT_W-1:0] quat_x,
    input logic signed [QUAT_W-1:0] quat_y,
    input logic signed [QUAT_W-1:0] quat_z,
    input logic signed [QUAT_W-1:0] quat_w,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [HEAD_W-1:0] heading,
    input logic [REGION_W-1:0]      region
);

    localparam logic signed [HEAD_W-1:0] PI_BOUND     = HEAD_W'(25800);
    localparam logic signed [HEAD_W-1:0] TWO_PI_BOUND = HEAD_W'(51600);

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(heading) && $stable(region))
        else $error("result changed while stalled");

    // a free output means every stage can move, so input is open
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output is free");

    // the normal branch is a plain atan2, inside plus or minus pi
    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && region == REGION_NORMAL |->
            heading <= PI_BOUND && heading >= -PI_BOUND)
        else $error("normal heading out of range");

    // singular branches are doubled and stay inside plus or minus two pi
    a_singular_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (region == REGION_NORTH || region == REGION_SOUTH) |->
            heading <= TWO_PI_BOUND && heading >= -TWO_PI_BOUND)
        else $error("singular heading out of range");

endmodule

bind quaternion_to_heading qth_checker u_qth_checker (.*);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_to_heading testbench
// Drives quaternions through the heading pipeline and compares every heading
// and region code with a typed value or a bit-exact fixed-point CORDIC
// predictor. A directed table covers branch boundaries and extremes, then
// constrained random traffic runs in three idle patterns, one long hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import qth_pkg::*;

    localparam int    STEPS          = CORDIC_STEPS_DEF;
    localparam int    LATENCY        = STEPS + 3;
    localparam int    WATCHDOG_LIMIT = 4000;
    localparam int    HOLD_CYCLES    = 300;
    localparam int    NUM_ROWS       = 24;
    localparam longint THRESH_Q28    = 133949292;
    localparam longint HALF_PI_ANG   = 421657428;
    localparam longint ONE_ANG       = 268435456;

    typedef struct packed {
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
        logic signed [QUAT_W-1:0] w;
    } quat_t;

    typedef struct packed {
        logic signed [HEAD_W-1:0] heading;
        region_t                  region;
    } heading_t;

    typedef struct packed {
        quat_t    quat;
        bit       known;     // heading typed in below
        heading_t result;
    } quat_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
    logic signed [QUAT_W-1:0] quat_w;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [HEAD_W-1:0] heading;
    logic [REGION_W-1:0]      region;

    heading_t pending_headings[$];
    int       mismatch_cnt  = 0;
    int       heading_count = 0;
    int       quiet_cycles  = 0;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       hold_request  = 1'b0;
    int       hold_left;

    longint atan_tab [0:23] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32
    };

    quat_row_t directed_rows [NUM_ROWS] = '{
        '{'{0, 0, 0, 0},                  1'b1, '{0, REGION_NORMAL}},
        '{'{0, 0, 0, 16384},              1'b1, '{0, REGION_NORMAL}},
        // both atan2 operands zero
        '{'{0, 8192, 8192, 0},            1'b1, '{0, REGION_NORMAL}},
        '{'{0, 8192, -8192, 0},           1'b1, '{0, REGION_NORMAL}},
        '{'{8192, 8192, 8192, 8192},      1'b0, '{0, REGION_NORMAL}},
        '{'{-8192, 8192, -8192, 8192},    1'b0, '{0, REGION_NORMAL}},
        '{'{-8192, -8192, -8192, -8192},  1'b0, '{0, REGION_NORMAL}},
        '{'{8192, -8192, -8192, 8192},    1'b0, '{0, REGION_NORMAL}},
        // test lands exactly on the threshold, then one step past it
        '{'{16384, 8175, 29, 348},        1'b0, '{0, REGION_NORMAL}},
        '{'{16384, 8175, 29, 349},        1'b0, '{0, REGION_NORMAL}},
        '{'{-16384, 8175, -29, 348},      1'b0, '{0, REGION_NORMAL}},
        '{'{-16384, 8175, -29, 349},      1'b0, '{0, REGION_NORMAL}},
        '{'{0, 16384, 0, 0},              1'b0, '{0, REGION_NORMAL}},
        '{'{0, 11585, 0, 11585},          1'b0, '{0, REGION_NORMAL}},
        '{'{0, -11585, 0, 11585},         1'b0, '{0, REGION_NORMAL}},
        '{'{0, 0, 0, -16384},             1'b1, '{0, REGION_NORMAL}},
        '{'{-16384, 0, 0, 0},             1'b1, '{0, REGION_NORMAL}},
        '{'{32767, 32767, 32767, 32767},  1'b0, '{0, REGION_NORMAL}},
        '{'{-32768, -32768, -32768, -32768}, 1'b0, '{0, REGION_NORMAL}},
        '{'{-32768, 32767, -32768, 32767}, 1'b0, '{0, REGION_NORMAL}},
        '{'{32767, -32768, 0, 0},         1'b0, '{0, REGION_NORMAL}},
        '{'{0, -32768, 32767, 0},         1'b0, '{0, REGION_NORMAL}},
        '{'{21845, -21846, 21845, -21846}, 1'b0, '{0, REGION_NORMAL}},
        '{'{-21846, 21845, -21846, 21845}, 1'b0, '{0, REGION_NORMAL}}
    };

    quaternion_to_heading #(
        .CORDIC_STEPS (STEPS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .heading   (heading),
        .region    (region)
    );

    always #2 clk = ~clk;

    // vectoring CORDIC, returns atan2(vy, vx) in Q28 radians
    function automatic longint cordic_atan2(input longint vy, input longint vx);
        longint ang;
        longint t;
        longint dx;
        longint dy;
        int     n;
        ang = 0;
        n   = (STEPS > 24) ? 24 : STEPS;
        if (vx == 0 && vy == 0)
            return 0;
        if (vx < 0)
        begin
            t = vx;
            if (vy >= 0)
            begin
                vx  = vy;
                vy  = -t;
                ang = HALF_PI_ANG;
            end
            else
            begin
                vx  = -vy;
                vy  = t;
                ang = -HALF_PI_ANG;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx  = vx + dx;
                vy  = vy - dy;
                ang = ang + atan_tab[i];
            end
            else
            begin
                vx  = vx - dx;
                vy  = vy + dy;
                ang = ang - atan_tab[i];
            end
        end
        return ang;
    endfunction

    function automatic heading_t predict_heading(input quat_t q);
        longint   x;
        longint   y;
        longint   z;
        longint   w;
        longint   tst;
        longint   ang;
        heading_t r;
        x   = q.x;
        y   = q.y;
        z   = q.z;
        w   = q.w;
        tst = x * y + z * w;
        if (tst > THRESH_Q28)
        begin
            ang      = 2 * cordic_atan2(x <<< 14, w <<< 14);
            r.region = REGION_NORTH;
        end
        else if (tst < -THRESH_Q28)
        begin
            ang      = -2 * cordic_atan2(x <<< 14, w <<< 14);
            r.region = REGION_SOUTH;
        end
        else
        begin
            ang      = cordic_atan2(2 * y * w - 2 * x * z, ONE_ANG - 2 * y * y - 2 * z * z);
            r.region = REGION_NORMAL;
        end
        r.heading = HEAD_W'((ang + 16384) >>> 15);
        return r;
    endfunction

    // mostly unit quaternions and near-gimbal-lock ones, the rest raw patterns
    function automatic quat_t random_quat();
        int    kind;
        real   c [4];
        real   nrm;
        quat_t q;
        int    sx;
        int    sz;
        bit    north;
        kind = $urandom_range(99);
        if (kind < 50)
        begin
            nrm = 0.0;
            for (int i = 0; i < 4; i++)
            begin
                c[i] = real'(int'($urandom_range(32768)) - 16384);
                nrm  = nrm + c[i] * c[i];
            end
            nrm = $sqrt(nrm);
            if (nrm < 1.0)
                q = '{0, 0, 0, 16384};
            else
            begin
                q.x = QUAT_W'($rtoi(c[0] * 16384.0 / nrm));
                q.y = QUAT_W'($rtoi(c[1] * 16384.0 / nrm));
                q.z = QUAT_W'($rtoi(c[2] * 16384.0 / nrm));
                q.w = QUAT_W'($rtoi(c[3] * 16384.0 / nrm));
            end
        end
        else if (kind < 70)
        begin
            sx    = $urandom_range(1) ? 1 : -1;
            sz    = $urandom_range(1) ? 1 : -1;
            north = 1'($urandom_range(1));
            q.x = QUAT_W'(sx * (8192 + int'($urandom_range(600)) - 300));
            q.y = QUAT_W'((north ? sx : -sx) * (8192 + int'($urandom_range(600)) - 300));
            q.z = QUAT_W'(sz * (8192 + int'($urandom_range(600)) - 300));
            q.w = QUAT_W'((north ? sz : -sz) * (8192 + int'($urandom_range(600)) - 300));
        end
        else if (kind < 85)
        begin
            q.x = QUAT_W'(int'($urandom_range(32768)) - 16384);
            q.y = QUAT_W'(int'($urandom_range(32768)) - 16384);
            q.z = QUAT_W'(int'($urandom_range(32768)) - 16384);
            q.w = QUAT_W'(int'($urandom_range(32768)) - 16384);
        end
        else
            q = {$urandom, $urandom};
        return q;
    endfunction

    // entered and left just after a falling edge
    task automatic send_quat(input quat_t q, input bit known, input heading_t typed);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        quat_x   <= q.x;
        quat_y   <= q.y;
        quat_z   <= q.z;
        quat_w   <= q.w;
        do
            @(posedge clk);
        while (!in_ready);
        pending_headings.push_back(known ? typed : predict_heading(q));
        @(negedge clk);
    endtask

    // receiver, with an optional long hold-off
    initial
    begin
        bit hold_seen;
        hold_seen = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_seen)
            begin
                hold_left = HOLD_CYCLES;
                hold_seen = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        heading_t exp_h;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_headings.size() == 0)
            begin
                if (mismatch_cnt < 10)
                    $display("unexpected transfer: heading %0d region %0d", heading, region);
                mismatch_cnt++;
            end
            else
            begin
                exp_h = pending_headings.pop_front();
                if (heading !== exp_h.heading || region !== exp_h.region)
                begin
                    if (mismatch_cnt < 10)
                        $display("result %0d: expected heading %0d region %0d, got %0d %0d",
                                 heading_count, exp_h.heading, exp_h.region, heading, region);
                    mismatch_cnt++;
                end
            end
            heading_count++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("quaternion_to_heading verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        quat_x        = '0;
        quat_y        = '0;
        quat_z        = '0;
        quat_w        = '0;
        send_idle_pct = 9;
        recv_idle_pct = 76;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
            send_quat(directed_rows[i].quat, directed_rows[i].known, directed_rows[i].result);

        for (int i = 0; i < 700; i++)
            send_quat(random_quat(), 1'b0, '0);

        send_idle_pct = 76;
        recv_idle_pct = 9;
        for (int i = 0; i < 700; i++)
            send_quat(random_quat(), 1'b0, '0);

        // no idling; output held off at first so the pipeline backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        for (int i = 0; i < 600; i++)
            send_quat(random_quat(), 1'b0, '0);
        in_valid <= 1'b0;

        while (pending_headings.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);

        if (mismatch_cnt == 0 && pending_headings.size() == 0)
            $display("quaternion_to_heading verification clean");
        else
            $display("quaternion_to_heading verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/qth_pkg.sv
sv/qth_cordic_stage.sv
sv/quaternion_to_heading.sv
sv/qth_checker.sv
dv/testbench.sv
